[rtl/mov_instruction_field_decoder_top_defines.svh]
// ---------------------------------------------------------------------------
// MOV decoder assertion macros
// Shared concurrent assertion forms for the MOV instruction field decoder.
// ---------------------------------------------------------------------------
`ifndef MOV_INSTRUCTION_FIELD_DECODER_TOP_DEFINES_SVH
`define MOV_INSTRUCTION_FIELD_DECODER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MOVDEC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("MOV decoder: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MOVDEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("MOV decoder: next-cycle check failed");

`endif

[rtl/movdec_pkg.sv]
// ---------------------------------------------------------------------------
// MOV decoder package
// Opcode patterns, field codes and the decoded record type.
// ---------------------------------------------------------------------------
package movdec_pkg;

    // Opcode patterns, compared against the upper bits of the opcode byte.
    localparam logic [5:0] OPC_RM_REG  = 6'b100010;
    localparam logic [6:0] OPC_IMM_RM  = 7'b1100011;
    localparam logic [3:0] OPC_IMM_REG = 4'b1011;
    localparam logic [6:0] OPC_MEM_ACC = 7'b1010000;

    // Instruction form codes.
    localparam logic [1:0] FORM_RM_REG  = 2'd0;
    localparam logic [1:0] FORM_IMM_RM  = 2'd1;
    localparam logic [1:0] FORM_IMM_REG = 2'd2;
    localparam logic [1:0] FORM_MEM_ACC = 2'd3;

    // ModRM mod codes.
    localparam logic [1:0] MOD_NO_DISP = 2'd0;
    localparam logic [1:0] MOD_DISP8   = 2'd1;
    localparam logic [1:0] MOD_DISP16  = 2'd2;
    localparam logic [1:0] MOD_REG     = 2'd3;

    // The rm code that means a direct 16-bit address under mod 0.
    localparam logic [2:0] RM_DIRECT = 3'd6;

    // One decoded MOV instruction.
    typedef struct packed {
        logic [1:0]  form;
        logic        wide;
        logic        to_register;
        logic [2:0]  reg_field;
        logic [1:0]  mod_field;
        logic [2:0]  rm_field;
        logic [15:0] displacement;
        logic        has_displacement;
        logic [15:0] immediate;
        logic        has_immediate;
    } t_rec;

endpackage

[rtl/mov_instruction_field_decoder_top.sv]
// A MOV's last byte is held in the input register; its record is registered in the result buffer.
// Throughput: one code byte per cycle, sustained while the result side is not stalled.
// The state loop in the core decoder, which advances once per decoded byte, sets that rate.
// Reset is synchronous and active low; the decoder returns to expecting an opcode byte.
// ---------------------------------------------------------------------------
// MOV instruction field decoder
// Decodes four 8086 MOV forms from a byte stream into one record each.
// ---------------------------------------------------------------------------
`include "mov_instruction_field_decoder_top_defines.svh"

module mov_instruction_field_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_code_valid,
    input  logic [7:0]  i_code_byte,
    output logic        o_code_stall,
    output logic        o_rec_valid,
    input  logic        i_rec_stall,
    output logic [1:0]  o_form,
    output logic        o_wide,
    output logic        o_to_register,
    output logic [2:0]  o_reg_field,
    output logic [1:0]  o_mod_field,
    output logic [2:0]  o_rm_field,
    output logic [15:0] o_displacement,
    output logic        o_has_displacement,
    output logic [15:0] o_immediate,
    output logic        o_has_immediate
);
    import movdec_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       w_room;
    logic       w_fire;
    logic       w_emit;
    t_rec       w_core_rec;
    t_rec       w_out_rec;
    logic       w_acc_rec;
    logic       w_acc_ok;

    // The held byte is decoded whenever the result buffer has room.
    assign w_fire       = r_in_valid && w_room;
    assign o_code_stall = r_in_valid && !w_room;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_code_stall) begin
            r_in_valid <= i_code_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_code_stall && i_code_valid) begin
            r_in_byte <= i_code_byte;
        end
    end

    movdec_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_byte  (r_in_byte),
        .o_emit  (w_emit),
        .o_rec   (w_core_rec)
    );

    movdec_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fire && w_emit),
        .i_rec   (w_core_rec),
        .o_room  (w_room),
        .o_valid (o_rec_valid),
        .i_stall (i_rec_stall),
        .o_rec   (w_out_rec)
    );

    // Result fields.
    assign o_form             = w_out_rec.form;
    assign o_wide             = w_out_rec.wide;
    assign o_to_register      = w_out_rec.to_register;
    assign o_reg_field        = w_out_rec.reg_field;
    assign o_mod_field        = w_out_rec.mod_field;
    assign o_rm_field         = w_out_rec.rm_field;
    assign o_displacement     = w_out_rec.displacement;
    assign o_has_displacement = w_out_rec.has_displacement;
    assign o_immediate        = w_out_rec.immediate;
    assign o_has_immediate    = w_out_rec.has_immediate;

    // Memory-to-accumulator items and the address shape they must carry.
    assign w_acc_rec = o_rec_valid && (o_form == FORM_MEM_ACC);
    assign w_acc_ok  = o_has_displacement && (o_rm_field == RM_DIRECT) &&
                       (o_mod_field == MOD_NO_DISP);

    // A full skid stage means the output register is occupied.
    `MOVDEC_ASSERT_SAME(a_skid_implies_out, i_clk, i_rst_n, !w_room, o_rec_valid)
    // A stalled input side always holds a byte that waits for buffer room.
    `MOVDEC_ASSERT_SAME(a_stall_has_byte, i_clk, i_rst_n, o_code_stall, r_in_valid && !w_room)
    // An item of the memory-to-accumulator form always carries a direct address.
    `MOVDEC_ASSERT_SAME(a_mem_acc_direct, i_clk, i_rst_n, w_acc_rec, w_acc_ok)
    // After a decoded item is pushed, the result side shows a valid item in the next cycle.
    `MOVDEC_ASSERT_NEXT(a_push_shows, i_clk, i_rst_n, w_fire && w_emit, o_rec_valid)

endmodule

[rtl/movdec_core.sv]
// ---------------------------------------------------------------------------
// MOV decoder core
// Holds the instruction assembly state and advances it by one code byte.
// ---------------------------------------------------------------------------
module movdec_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [7:0]        i_byte,
    output logic              o_emit,
    output movdec_pkg::t_rec  o_rec
);
    import movdec_pkg::*;

    typedef enum logic [2:0] {
        PH_OPCODE,
        PH_MODRM,
        PH_DLO,
        PH_DHI,
        PH_ILO,
        PH_IHI
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_form, n_form;
    logic        r_wide, n_wide;
    logic        r_dir, n_dir;
    logic [7:0]  r_modrm, n_modrm;
    logic [15:0] r_disp, n_disp;
    logic [15:0] r_imm, n_imm;
    logic        n_emit;
    logic        n_byte_disp;

    // A ModRM byte is followed by a displacement for mod 1, mod 2 and the direct address.
    assign n_byte_disp = (i_byte[7:6] == MOD_DISP8) || (i_byte[7:6] == MOD_DISP16) ||
                         ((i_byte[7:6] == MOD_NO_DISP) && (i_byte[2:0] == RM_DIRECT));

    // Next-state decode for one byte.
    always_comb begin
        n_phase = r_phase;
        n_form  = r_form;
        n_wide  = r_wide;
        n_dir   = r_dir;
        n_modrm = r_modrm;
        n_disp  = r_disp;
        n_imm   = r_imm;
        n_emit  = 1'b0;
        unique case (r_phase)
            PH_MODRM: begin
                n_modrm = i_byte;
                if (n_byte_disp) begin
                    n_phase = PH_DLO;
                end else if (r_form == FORM_IMM_RM) begin
                    n_phase = PH_ILO;
                end else begin
                    n_emit  = 1'b1;
                    n_phase = PH_OPCODE;
                end
            end
            PH_DLO: begin
                if (r_modrm[7:6] == MOD_DISP8) begin
                    n_disp = {{8{i_byte[7]}}, i_byte};
                    if (r_form == FORM_IMM_RM) begin
                        n_phase = PH_ILO;
                    end else begin
                        n_emit  = 1'b1;
                        n_phase = PH_OPCODE;
                    end
                end else begin
                    n_disp  = {8'h00, i_byte};
                    n_phase = PH_DHI;
                end
            end
            PH_DHI: begin
                n_disp = {i_byte, r_disp[7:0]};
                if (r_form == FORM_IMM_RM) begin
                    n_phase = PH_ILO;
                end else begin
                    n_emit  = 1'b1;
                    n_phase = PH_OPCODE;
                end
            end
            PH_ILO: begin
                n_imm = {8'h00, i_byte};
                if (r_wide) begin
                    n_phase = PH_IHI;
                end else begin
                    n_emit  = 1'b1;
                    n_phase = PH_OPCODE;
                end
            end
            PH_IHI: begin
                n_imm   = {i_byte, r_imm[7:0]};
                n_emit  = 1'b1;
                n_phase = PH_OPCODE;
            end
            default: begin
                // Opcode byte; the unused phase codes land here as well.
                n_phase = PH_OPCODE;
                n_disp  = '0;
                n_imm   = '0;
                if (i_byte[7:2] == OPC_RM_REG) begin
                    n_form  = FORM_RM_REG;
                    n_wide  = i_byte[0];
                    n_dir   = i_byte[1];
                    n_phase = PH_MODRM;
                end else if (i_byte[7:1] == OPC_IMM_RM) begin
                    n_form  = FORM_IMM_RM;
                    n_wide  = i_byte[0];
                    n_dir   = 1'b0;
                    n_phase = PH_MODRM;
                end else if (i_byte[7:4] == OPC_IMM_REG) begin
                    n_form  = FORM_IMM_REG;
                    n_wide  = i_byte[3];
                    n_dir   = 1'b1;
                    n_modrm = {MOD_NO_DISP, i_byte[2:0], 3'd0};
                    n_phase = PH_ILO;
                end else if (i_byte[7:1] == OPC_MEM_ACC) begin
                    n_form  = FORM_MEM_ACC;
                    n_wide  = i_byte[0];
                    n_dir   = 1'b1;
                    n_modrm = {MOD_NO_DISP, 3'd0, RM_DIRECT};
                    n_phase = PH_DLO;
                end
            end
        endcase
    end

    // Assemble the record from the updated state.
    always_comb begin
        o_emit               = n_emit;
        o_rec.form           = n_form;
        o_rec.wide           = n_wide;
        o_rec.to_register    = n_dir;
        o_rec.reg_field      = n_modrm[5:3];
        o_rec.mod_field      = n_modrm[7:6];
        o_rec.rm_field       = n_modrm[2:0];
        o_rec.displacement   = n_disp;
        o_rec.immediate      = n_imm;
        o_rec.has_immediate  = (n_form == FORM_IMM_RM) || (n_form == FORM_IMM_REG);
        case (n_form)
            FORM_IMM_REG: o_rec.has_displacement = 1'b0;
            FORM_MEM_ACC: o_rec.has_displacement = 1'b1;
            default: o_rec.has_displacement = (n_modrm[7:6] == MOD_DISP8) ||
                                              (n_modrm[7:6] == MOD_DISP16) ||
                                              ((n_modrm[7:6] == MOD_NO_DISP) &&
                                               (n_modrm[2:0] == RM_DIRECT));
        endcase
    end

    // State registers advance once per decoded byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_OPCODE;
            r_form  <= '0;
            r_wide  <= 1'b0;
            r_dir   <= 1'b0;
            r_modrm <= '0;
            r_disp  <= '0;
            r_imm   <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_form  <= n_form;
            r_wide  <= n_wide;
            r_dir   <= n_dir;
            r_modrm <= n_modrm;
            r_disp  <= n_disp;
            r_imm   <= n_imm;
        end
    end

endmodule

[rtl/movdec_outbuf.sv]
// ---------------------------------------------------------------------------
// MOV decoder result buffer
// Output register with a skid stage; the core waits on the stall only when the skid stage is full.
// ---------------------------------------------------------------------------
module movdec_outbuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  movdec_pkg::t_rec  i_rec,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_stall,
    output movdec_pkg::t_rec  o_rec
);
    import movdec_pkg::*;

    logic  r_out_valid;
    logic  r_skd_valid;
    t_rec  r_out;
    t_rec  r_skd;
    logic  n_load_out;

    // The output register takes a new item when it is empty or being drained.
    assign n_load_out = !r_out_valid || !i_stall;
    assign o_room     = !r_skd_valid;
    assign o_valid    = r_out_valid;
    assign o_rec      = r_out;

    // Valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (n_load_out) begin
            r_out_valid <= r_skd_valid || i_push;
            r_skd_valid <= 1'b0;
        end else if (i_push) begin
            r_skd_valid <= 1'b1;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (n_load_out) begin
            r_out <= r_skd_valid ? r_skd : i_rec;
        end else if (i_push) begin
            r_skd <= i_rec;
        end
    end

endmodule
